// ===== sv/suli_pkg.sv =====
`timescale 1ns / 1ps

package suli_pkg;

    localparam int TABLE_DEPTH      = 404;
    localparam int STEPS_PER_RADIAN = 64;
    localparam int FRAC_BITS        = 22;
    localparam int SAMPLE_W         = 32;

    localparam longint TWO_PI_Q22   = 64'sd26353589;
    localparam int     RECIP_SHIFT  = 40;
    localparam longint RECIP_Q40    = (64'sd1 <<< RECIP_SHIFT) / TWO_PI_Q22;
    localparam int     RECIP_W      = $clog2(RECIP_Q40 + 1) + 1;

    localparam int WRAP_W  = $clog2(TWO_PI_Q22);
    localparam int X_W     = $clog2(TWO_PI_Q22 * STEPS_PER_RADIAN);
    localparam int F_W     = X_W + 1 - FRAC_BITS;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);

    localparam int EVEN_DEPTH = (TABLE_DEPTH + 1) / 2;
    localparam int ODD_DEPTH  = TABLE_DEPTH / 2;
    localparam int BANK_AW    = $clog2(EVEN_DEPTH);

    localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
    localparam logic [63:0] ONE_Q56     = 64'h0100000000000000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [BANK_AW-1:0]         bank_addr_t;
    typedef sample_t                    even_bank_t [EVEN_DEPTH];
    typedef sample_t                    odd_bank_t  [ODD_DEPTH];

    function automatic logic [63:0] mul_q56(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[119:56];
    endfunction

    // unsigned long division, used only while building the table
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // trunc(sin(idx / STEPS_PER_RADIAN) * 2^31), Q56 series, saturated
    function automatic sample_t rom_entry(int idx);
        logic [63:0]        ang;
        logic [63:0]        k;
        logic [63:0]        r;
        logic [63:0]        r2;
        logic [63:0]        term;
        logic [63:0]        n;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        logic signed [63:0] t;
        logic               neg;
        logic               done;
        ang = (64'(idx / STEPS_PER_RADIAN) << 56)
            + ((64'(idx % STEPS_PER_RADIAN) << 56) / 64'(STEPS_PER_RADIAN));
        k   = udiv64(ang, HALF_PI_Q56);
        r   = ang - k * HALF_PI_Q56;
        r2  = mul_q56(r, r);
        if (k[0]) begin
            term = ONE_Q56;
            n    = 64'd1;
        end else begin
            term = r;
            n    = 64'd2;
        end
        sum  = $signed(term);
        neg  = 1'b1;
        done = 1'b0;
        for (int j = 0; j < 48; j++) begin
            if (!done) begin
                if (term == 64'd0) begin
                    done = 1'b1;
                end else begin
                    term = udiv64(mul_q56(term, r2), n * (n + 64'd1));
                    sum  = neg ? sum - $signed(term) : sum + $signed(term);
                    neg  = !neg;
                    n    = n + 64'd2;
                end
            end
        end
        v = k[1] ? -sum : sum;
        if (v >= 0) begin
            t = v >>> 25;
        end else begin
            t = -$signed(64'($unsigned(-v) >> 25));
        end
        if (t > 64'sd2147483647) begin
            t = 64'sd2147483647;
        end
        if (t < -64'sd2147483648) begin
            t = -64'sd2147483648;
        end
        return sample_t'(t[SAMPLE_W-1:0]);
    endfunction

    function automatic even_bank_t build_even_bank();
        even_bank_t b;
        for (int i = 0; i < EVEN_DEPTH; i++) begin
            b[i] = rom_entry(2 * i);
        end
        return b;
    endfunction

    function automatic odd_bank_t build_odd_bank();
        odd_bank_t b;
        for (int i = 0; i < ODD_DEPTH; i++) begin
            b[i] = rom_entry(2 * i + 1);
        end
        return b;
    endfunction

    localparam even_bank_t EVEN_ROM = build_even_bank();
    localparam odd_bank_t  ODD_ROM  = build_odd_bank();

endpackage

// ===== sv/sine_uniform_lut_interp_top.sv =====
`timescale 1ns / 1ps
// pipeline: seven register stages from input accept to m_valid
// throughput: one item per cycle; a stage holds only while every stage after it is full
// and the output is not taken; the table is read once per item from two banks
// reset: aresetn synchronous active low, clears all valid bits and sets interp_mode to 1

module sine_uniform_lut_interp_top
    import suli_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_angle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_sine_value
);

    localparam int NSTAGE   = 7;
    localparam int PROD0_W  = SAMPLE_W + RECIP_W;
    localparam int Q_W      = PROD0_W - RECIP_SHIFT;
    localparam int REMC_W   = Q_W + WRAP_W + 1;
    localparam int REM_W    = WRAP_W + 2;
    localparam int SLOPE_W  = SAMPLE_W + 1;
    localparam int PROD5_W  = SLOPE_W + FRAC_BITS + 1;

    localparam logic signed [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_Q40);
    localparam logic signed [WRAP_W:0]    TWO_PI_C = (WRAP_W + 1)'(TWO_PI_Q22);
    localparam logic [X_W:0]              HALF_C   = (X_W + 1)'(64'd1 << (FRAC_BITS - 1));

    function automatic logic [IDX_W-1:0] clamp_idx(logic [F_W-1:0] v);
        if (int'(v) > TABLE_DEPTH - 1) begin
            return IDX_W'(TABLE_DEPTH - 1);
        end
        return IDX_W'(v);
    endfunction

    logic                      interp_mode_reg;
    logic [NSTAGE-1:0]         vld_reg;
    logic [NSTAGE-1:0]         vld_next;
    logic [NSTAGE-1:0]         adv;

    logic signed [31:0]        a0_reg;
    logic signed [PROD0_W-1:0] prod0_reg;
    logic signed [PROD0_W-1:0] prod0_next;

    logic signed [Q_W-1:0]     q1;
    logic signed [REMC_W-1:0]  rem1_calc;
    logic signed [REM_W-1:0]   rem1_reg;

    logic [WRAP_W-1:0]         wrap_r;
    logic [X_W-1:0]            x2;
    logic [F_W-1:0]            f2;
    logic [F_W-1:0]            rnd2;
    logic [IDX_W-1:0]          i0_next;
    logic [IDX_W-1:0]          i1_next;
    logic [FRAC_BITS-1:0]      frac_next;
    logic [IDX_W-1:0]          i0_reg;
    logic [IDX_W-1:0]          i1_reg;
    logic [FRAC_BITS-1:0]      frac2_reg;

    bank_addr_t                ev_addr;
    bank_addr_t                od_addr;
    sample_t                   ev_data;
    sample_t                   od_data;
    logic                      lo_odd3_reg;
    logic                      same3_reg;
    logic [FRAC_BITS-1:0]      frac3_reg;

    sample_t                   y0;
    sample_t                   y1;
    sample_t                   y0_4_reg;
    logic signed [SLOPE_W-1:0] slope4_reg;
    logic [FRAC_BITS-1:0]      frac4_reg;

    sample_t                   y0_5_reg;
    logic signed [PROD5_W-1:0] prod5_reg;
    logic signed [PROD5_W-1:0] prod5_next;

    sample_t                   sine_next;
    sample_t                   m_sine_value_reg;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interp_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            interp_mode_reg <= cfg_wr_data;
        end
    end

    // stage advance chain, bubbles collapse
    always_comb begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = {vld_reg[NSTAGE-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_ready = adv[0];

    // stage 0: reciprocal multiply for the quotient by 2*pi
    assign prod0_next = PROD0_W'(s_angle) * PROD0_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a0_reg    <= s_angle;
            prod0_reg <= prod0_next;
        end
    end

    // stage 1: remainder, off by at most one period
    always_comb begin
        q1        = Q_W'(prod0_reg >>> RECIP_SHIFT);
        rem1_calc = REMC_W'(a0_reg) - REMC_W'(q1) * REMC_W'(TWO_PI_C);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            rem1_reg <= REM_W'(rem1_calc);
        end
    end

    // stage 2: wrap into [0, 2*pi), scale, table indices
    always_comb begin
        priority if (rem1_reg < 0) begin
            wrap_r = WRAP_W'(rem1_reg + REM_W'(TWO_PI_C));
        end else if (rem1_reg >= REM_W'(TWO_PI_C)) begin
            wrap_r = WRAP_W'(rem1_reg - REM_W'(TWO_PI_C));
        end else begin
            wrap_r = WRAP_W'(rem1_reg);
        end
        x2   = X_W'(wrap_r) * X_W'(STEPS_PER_RADIAN);
        f2   = F_W'(x2 >> FRAC_BITS);
        rnd2 = F_W'(({1'b0, x2} + HALF_C) >> FRAC_BITS);
        if (interp_mode_reg) begin
            i0_next   = clamp_idx(f2);
            i1_next   = clamp_idx(f2 + F_W'(1));
            frac_next = x2[FRAC_BITS-1:0];
        end else begin
            i0_next   = clamp_idx(rnd2);
            i1_next   = clamp_idx(rnd2);
            frac_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            i0_reg    <= i0_next;
            i1_reg    <= i1_next;
            frac2_reg <= frac_next;
        end
    end

    // stage 3: table read
    always_comb begin
        if (i0_reg[0]) begin
            ev_addr = BANK_AW'(i1_reg >> 1);
            od_addr = BANK_AW'(i0_reg >> 1);
        end else begin
            ev_addr = BANK_AW'(i0_reg >> 1);
            od_addr = BANK_AW'(i1_reg >> 1);
        end
    end

    suli_rom u_rom (
        .aclk    (aclk),
        .en      (adv[3]),
        .ev_addr (ev_addr),
        .od_addr (od_addr),
        .ev_data (ev_data),
        .od_data (od_data)
    );

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            lo_odd3_reg <= i0_reg[0];
            same3_reg   <= (i0_reg == i1_reg);
            frac3_reg   <= frac2_reg;
        end
    end

    // stage 4: pick entries, slope
    always_comb begin
        y0 = lo_odd3_reg ? od_data : ev_data;
        if (same3_reg) begin
            y1 = y0;
        end else begin
            y1 = lo_odd3_reg ? ev_data : od_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            y0_4_reg   <= y0;
            slope4_reg <= SLOPE_W'(y1) - SLOPE_W'(y0);
            frac4_reg  <= frac3_reg;
        end
    end

    // stage 5: slope times fraction
    assign prod5_next = PROD5_W'(slope4_reg) * PROD5_W'($signed({1'b0, frac4_reg}));

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            y0_5_reg  <= y0_4_reg;
            prod5_reg <= prod5_next;
        end
    end

    // stage 6: add floored correction
    assign sine_next = y0_5_reg + SAMPLE_W'(prod5_reg >>> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            m_sine_value_reg <= sine_next;
        end
    end

    assign m_valid      = vld_reg[NSTAGE-1];
    assign m_sine_value = m_sine_value_reg;

    a_wrap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> (WRAP_W + 1)'(wrap_r) < $unsigned(TWO_PI_C))
        else $error("wrapped angle out of range");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NSTAGE-1] |-> s_ready)
        else $error("input stalled while output stage empty");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] && adv[1] |=> vld_reg[1])
        else $error("item lost between stage 0 and stage 1");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted item not in stage 0");

endmodule

// ===== sv/suli_rom.sv =====
`timescale 1ns / 1ps

module suli_rom
    import suli_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  bank_addr_t ev_addr,
    input  bank_addr_t od_addr,
    output sample_t    ev_data,
    output sample_t    od_data
);

    sample_t ev_data_reg;
    sample_t od_data_reg;
    sample_t ev_data_next;
    sample_t od_data_next;

    // even entries in one bank, odd entries in the other
    always_comb begin
        ev_data_next = EVEN_ROM[ev_addr];
        if (int'(od_addr) < ODD_DEPTH) begin
            od_data_next = ODD_ROM[od_addr];
        end else begin
            od_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ev_data_reg <= ev_data_next;
            od_data_reg <= od_data_next;
        end
    end

    assign ev_data = ev_data_reg;
    assign od_data = od_data_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import suli_pkg::*;

    localparam int     CLK_HALF    = 5;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     TAIL_CYCLES = 30;
    localparam longint HALF_LSB    = 64'sd1 <<< (FRAC_BITS - 1);

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic               cfg_wr_data  = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_angle      = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic signed [31:0] m_sine_value;

    logic signed [31:0] pending_angles [$];
    logic signed [31:0] expected_sines [$];
    longint             sine_table [TABLE_DEPTH];
    logic               lerp_on      = 1'b1;
    bit                 idle_on      = 1'b1;
    int                 send_gap     = 0;
    int                 recv_gap     = 0;
    int                 error_count  = 0;
    int                 cycle_count  = 0;

    sine_uniform_lut_interp_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_angle      (s_angle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sine_value (m_sine_value)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [63:0] q56_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        return full[119:56];
    endfunction

    // sin(i / 64) from the Q56 series, in q0.31, truncated toward zero
    function automatic longint table_sine(int i);
        logic [63:0] ang;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] rem_sq;
        logic [63:0] term;
        logic [63:0] n;
        longint      acc;
        longint      v;
        longint      t;
        bit          subtract;
        int          k;
        ang  = (64'(i / STEPS_PER_RADIAN) << 56)
             + ((64'(i % STEPS_PER_RADIAN) << 56) / 64'(STEPS_PER_RADIAN));
        quad = ang / HALF_PI_Q56;
        rem  = ang - quad * HALF_PI_Q56;
        rem_sq = q56_product(rem, rem);
        if (quad[0]) begin
            term = ONE_Q56;
            n    = 64'd1;
        end else begin
            term = rem;
            n    = 64'd2;
        end
        acc = longint'(term);
        subtract = 1'b1;
        for (k = 0; k < 48 && term != 64'd0; k++) begin
            term = q56_product(term, rem_sq) / (n * (n + 64'd1));
            acc  = subtract ? acc - longint'(term) : acc + longint'(term);
            subtract = !subtract;
            n = n + 64'd2;
        end
        v = quad[1] ? -acc : acc;
        t = (v >= 0) ? (v >>> 25) : -((-v) >>> 25);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return t;
    endfunction

    function automatic int clamp_row(longint idx);
        if (idx < 0) return 0;
        if (idx > TABLE_DEPTH - 1) return TABLE_DEPTH - 1;
        return int'(idx);
    endfunction

    function automatic logic signed [31:0] sine_of_angle(logic signed [31:0] angle,
                                                         logic lerp);
        longint wrapped;
        longint scaled;
        longint row;
        longint lo_val;
        longint slope;
        longint span;
        longint sine;
        wrapped = longint'(angle) % TWO_PI_Q22;
        if (wrapped < 0) wrapped = wrapped + TWO_PI_Q22;
        scaled = wrapped * STEPS_PER_RADIAN;
        if (!lerp) begin
            sine = sine_table[clamp_row((scaled + HALF_LSB) >>> FRAC_BITS)];
        end else begin
            row    = scaled >>> FRAC_BITS;
            lo_val = sine_table[clamp_row(row)];
            slope  = sine_table[clamp_row(row + 1)] - lo_val;
            span   = scaled - (row <<< FRAC_BITS);
            sine   = lo_val + ((slope * span) >>> FRAC_BITS);
        end
        return sine[31:0];
    endfunction

    function automatic logic signed [31:0] random_angle();
        int unsigned u;
        int          turns;
        int          offset;
        int          row;
        longint      v;
        case ($urandom_range(0, 3))
            0: begin
                v = longint'($signed($urandom));
            end
            1: begin
                u = $urandom_range(0, 8 * 26353589);
                v = longint'(u) - 4 * TWO_PI_Q22;
            end
            2: begin
                turns  = $urandom_range(0, 162);
                offset = $urandom_range(0, 4);
                v = longint'(turns - 81) * TWO_PI_Q22 + (offset - 2);
            end
            default: begin
                // around the half-step rounding point of a random row
                turns  = $urandom_range(0, 80);
                row    = $urandom_range(0, 401);
                offset = $urandom_range(0, 2);
                v = longint'(turns - 40) * TWO_PI_Q22 + longint'(row) * 65536
                  + 32768 + (offset - 1);
            end
        endcase
        return v[31:0];
    endfunction

    task automatic push_directed();
        logic signed [31:0] corner [$];
        corner = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
                   32'sd26353589, 32'sd26353588, -32'sd26353589, -32'sd26353588,
                   32'sd6588397, 32'sd13176794, 32'sd19765192,
                   32'sd32767, 32'sd32768, 32'sd65535, 32'sd65536,
                   32'sd26320821, 32'sd2108287125, -32'sd2134640712,
                   32'sh55555555, 32'shAAAAAAAA};
        foreach (corner[i]) pending_angles.push_back(corner[i]);
    endtask

    task automatic wait_drained();
        while (pending_angles.size() != 0 || s_valid || expected_sines.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_mode(logic lerp);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lerp;
        lerp_on = lerp;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_random(int count);
        repeat (count) pending_angles.push_back(random_angle());
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_angle <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_sines.push_back(sine_of_angle(s_angle, lerp_on));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_angles.size() != 0) begin
                    s_valid <= 1'b1;
                    s_angle <= pending_angles.pop_front();
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 7);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic signed [31:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_sines.size() == 0) begin
                    $error("unexpected item: sine_value %0d", m_sine_value);
                    error_count++;
                end else begin
                    want = expected_sines.pop_front();
                    if (m_sine_value !== want) begin
                        $error("sine_value mismatch: expected %0d, actual %0d",
                               want, m_sine_value);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    recv_gap = $urandom_range(1, 7);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) sine_table[i] = table_sine(i);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // interpolation is the reset mode
        push_directed();
        write_mode(1'b0);
        push_directed();

        push_random(500);
        write_mode(1'b1);
        push_random(500);
        write_mode(1'b0);
        push_random(500);
        write_mode(1'b1);
        wait_drained();
        idle_on = 1'b0;
        push_random(500);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_sines.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sine_uniform_lut_interp_top.f =====
sv/suli_pkg.sv
sv/suli_rom.sv
sv/sine_uniform_lut_interp_top.sv
tb/sv/tb.sv
